>>> src/lfu_pkg.sv
// Shared types and constants for the LFU cache set with recency tie-break.
`default_nettype none

package lfu_pkg;

	// Set geometry and field widths.
	localparam int WAYS       = 8;
	localparam int IDX_BITS   = $clog2(WAYS);
	localparam int RANK_BITS  = IDX_BITS;
	localparam int OCC_BITS   = $clog2(WAYS + 1);
	localparam int TAG_BITS   = 20;
	localparam int COUNT_BITS = 16;
	localparam int CFG_BITS   = 4;

	// Count limits and the reset value of the way limit register.
	localparam logic [COUNT_BITS-1:0] COUNT_MAX       = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_ONE       = COUNT_BITS'(1);
	localparam logic [CFG_BITS-1:0]   WAYS_IN_USE_RST = CFG_BITS'(8);

	// Operation codes.
	localparam logic OP_ACCESS = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	// Request as it arrives on the input channel.
	typedef struct packed {
		logic                op;
		logic [TAG_BITS-1:0] tag;
	} req_t;

	// Result as it leaves on the output channel.
	typedef struct packed {
		logic                  hit;
		logic                  evicted;
		logic [TAG_BITS-1:0]   victim_tag;
		logic [COUNT_BITS-1:0] use_count;
		logic [OCC_BITS-1:0]   lines_held;
	} rsp_t;

	// Classified request held in the queue between front and back.
	typedef struct packed {
		logic                is_flush;
		logic [TAG_BITS-1:0] tag;
	} item_t;

endpackage

`default_nettype wire

>>> src/lfu_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
`default_nettype none

module lfu_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	input  lfu_pkg::req_t       req,
	output logic                q_valid,
	input  wire                 q_pop,
	output lfu_pkg::item_t      q_item
);
	import lfu_pkg::*;

	localparam int QDEPTH   = 2;
	localparam int PTR_BITS = $clog2(QDEPTH);
	localparam int CNT_BITS = $clog2(QDEPTH + 1);

	item_t               mem_q [QDEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                push;
	item_t               item_in;

	// Classify the request; the tag is irrelevant for a flush.
	always_comb begin
		item_in.is_flush = (req.op == OP_FLUSH);
		item_in.tag      = item_in.is_flush ? '0 : req.tag;
	end

	// Queue status.
	assign req_stall = (cnt_q == CNT_BITS'(QDEPTH));
	assign push      = req_valid && !req_stall;
	assign q_valid   = (cnt_q != '0);
	assign q_item    = mem_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
			end else if (q_pop && !push) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
			end
		end
	end

	// The back end only pops a request that is there.
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (cnt_q != '0))
		else $error("queue popped while empty");

	// The fill count never passes the queue depth.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_BITS'(QDEPTH))
		else $error("queue fill count out of range");

endmodule

`default_nettype wire

>>> src/lfu_back.sv
// Back end: holds the set, looks up each request, picks a victim and updates the lines.
`default_nettype none

module lfu_back (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire [lfu_pkg::OCC_BITS-1:0]    limit,
	input  wire                            q_valid,
	output logic                           q_pop,
	input  lfu_pkg::item_t                 q_item,
	output logic                           rsp_valid,
	input  wire                            rsp_stall,
	output lfu_pkg::rsp_t                  rsp
);
	import lfu_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	localparam int NODES    = 1 << IDX_BITS;
	localparam int KEY_BITS = COUNT_BITS + RANK_BITS;

	// Lookup results registered between the two steps of a request.
	typedef struct packed {
		logic                  is_flush;
		logic [TAG_BITS-1:0]   tag;
		logic                  hit;
		logic [IDX_BITS-1:0]   hit_idx;
		logic [RANK_BITS-1:0]  hit_rank;
		logic [COUNT_BITS-1:0] hit_cnt;
		logic                  full;
		logic [IDX_BITS-1:0]   vic_idx;
		logic [RANK_BITS-1:0]  vic_rank;
		logic [TAG_BITS-1:0]   vic_tag;
		logic                  free_ok;
		logic [IDX_BITS-1:0]   free_idx;
	} look_t;

	// Set state.
	logic [WAYS-1:0]       valid_q;
	logic [TAG_BITS-1:0]   tag_q  [WAYS];
	logic [COUNT_BITS-1:0] cnt_q  [WAYS];
	logic [RANK_BITS-1:0]  rank_q [WAYS];
	logic [OCC_BITS-1:0]   occ_q;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	item_t      req_s1;
	look_t      look_s2;
	look_t      look;
	logic       commit;
	rsp_t       rsp_q;
	logic       rsp_valid_q;

	logic [WAYS-1:0]       match;
	logic [2*NODES-1:0]    nd_v;
	logic [KEY_BITS-1:0]   nd_key [2*NODES];
	logic [IDX_BITS-1:0]   nd_idx [2*NODES];
	logic [TAG_BITS-1:0]   nd_tag [2*NODES];

	logic                  evict;
	logic [IDX_BITS-1:0]   slot;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [WAYS-1:0]       valid_nxt;
	logic [OCC_BITS-1:0]   occ_nxt;

	// Sequencer: pop, look up, then commit when the output register is free.
	assign commit = (state_q == ST_UPD) && (!rsp_valid_q || !rsp_stall);
	assign q_pop  = q_valid && ((state_q == ST_IDLE) || commit);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: state_nxt = q_pop ? ST_LOOK : ST_IDLE;
			ST_LOOK: state_nxt = ST_UPD;
			ST_UPD: begin
				if (commit) begin
					state_nxt = q_pop ? ST_LOOK : ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Tag match, lowest free way and the remaining lookup fields.
	always_comb begin
		match         = '0;
		look.hit_idx  = '0;
		look.hit_rank = '0;
		look.hit_cnt  = '0;
		look.free_idx = '0;
		for (int w = 0; w < WAYS; w++) begin
			match[w] = valid_q[w] && (tag_q[w] == req_s1.tag);
			if (match[w]) begin
				look.hit_idx  = look.hit_idx | IDX_BITS'(w);
				look.hit_rank = look.hit_rank | rank_q[w];
				look.hit_cnt  = look.hit_cnt | cnt_q[w];
			end
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (!valid_q[w]) begin
				look.free_idx = IDX_BITS'(w);
			end
		end
		look.is_flush = req_s1.is_flush;
		look.tag      = req_s1.tag;
		look.hit      = |match;
		look.full     = (occ_q >= limit);
		look.vic_idx  = nd_idx[1];
		look.vic_rank = ~nd_key[1][RANK_BITS-1:0];
		look.vic_tag  = nd_tag[1];
		look.free_ok  = ~&valid_q;
	end

	// Victim tree: lowest count wins, and among equal counts the oldest line.
	always_comb begin
		nd_v = '0;
		for (int n = 0; n < 2 * NODES; n++) begin
			nd_key[n] = '0;
			nd_idx[n] = '0;
			nd_tag[n] = '0;
		end
		for (int i = 0; i < NODES; i++) begin
			if (i < WAYS) begin
				nd_v[NODES + i]   = valid_q[i];
				nd_key[NODES + i] = {cnt_q[i], ~rank_q[i]};
				nd_idx[NODES + i] = IDX_BITS'(i);
				nd_tag[NODES + i] = tag_q[i];
			end
		end
		for (int n = NODES - 1; n >= 1; n--) begin
			if (nd_v[2*n] && (!nd_v[2*n+1] || (nd_key[2*n] <= nd_key[2*n+1]))) begin
				nd_v[n]   = 1'b1;
				nd_key[n] = nd_key[2*n];
				nd_idx[n] = nd_idx[2*n];
				nd_tag[n] = nd_tag[2*n];
			end else begin
				nd_v[n]   = nd_v[2*n+1];
				nd_key[n] = nd_key[2*n+1];
				nd_idx[n] = nd_idx[2*n+1];
				nd_tag[n] = nd_tag[2*n+1];
			end
		end
	end

	// Request and lookup pipeline registers.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			req_s1 <= q_item;
		end
		if (state_q == ST_LOOK) begin
			look_s2 <= look;
		end
	end

	// Update decisions from the registered lookup.
	always_comb begin
		evict   = !look_s2.is_flush && !look_s2.hit && look_s2.full;
		if (look_s2.full) begin
			slot = (look_s2.free_ok && (look_s2.free_idx < look_s2.vic_idx)) ?
				look_s2.free_idx : look_s2.vic_idx;
		end else begin
			slot = look_s2.free_idx;
		end
		cnt_inc = (look_s2.hit_cnt == COUNT_MAX) ? look_s2.hit_cnt :
			look_s2.hit_cnt + COUNT_ONE;
		valid_nxt = valid_q;
		occ_nxt   = occ_q;
		if (look_s2.is_flush) begin
			valid_nxt = '0;
			occ_nxt   = '0;
		end else if (!look_s2.hit) begin
			if (evict) begin
				valid_nxt[look_s2.vic_idx] = 1'b0;
			end else begin
				occ_nxt = occ_q + OCC_BITS'(1);
			end
			valid_nxt[slot] = 1'b1;
		end
	end

	// Line payload: tags, counts and recency ranks.
	always_ff @(posedge clk) begin
		if (commit && !look_s2.is_flush) begin
			for (int w = 0; w < WAYS; w++) begin
				if (look_s2.hit) begin
					if (valid_q[w] && (rank_q[w] < look_s2.hit_rank)) begin
						rank_q[w] <= rank_q[w] + RANK_BITS'(1);
					end
					if (IDX_BITS'(w) == look_s2.hit_idx) begin
						rank_q[w] <= '0;
						cnt_q[w]  <= cnt_inc;
					end
				end else begin
					if (valid_q[w] && !(evict && (IDX_BITS'(w) == look_s2.vic_idx))) begin
						rank_q[w] <= rank_q[w]
							- RANK_BITS'(evict && (rank_q[w] > look_s2.vic_rank))
							+ RANK_BITS'(1);
					end
					if (IDX_BITS'(w) == slot) begin
						tag_q[w]  <= look_s2.tag;
						cnt_q[w]  <= COUNT_ONE;
						rank_q[w] <= '0;
					end
				end
			end
		end
	end

	// Valid bits and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
		end else if (commit) begin
			valid_q <= valid_nxt;
			occ_q   <= occ_nxt;
		end
	end

	// Output register: loaded on commit, emptied when the receiver takes it.
	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_q.hit        <= !look_s2.is_flush && look_s2.hit;
			rsp_q.evicted    <= evict;
			rsp_q.victim_tag <= evict ? look_s2.vic_tag : '0;
			if (look_s2.is_flush) begin
				rsp_q.use_count <= '0;
			end else if (look_s2.hit) begin
				rsp_q.use_count <= cnt_inc;
			end else begin
				rsp_q.use_count <= COUNT_ONE;
			end
			rsp_q.lines_held <= occ_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Occupancy always agrees with the valid bits.
	a_occ_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == 32'(occ_q))
		else $error("occupancy disagrees with valid bits");

	// Tags of valid lines are unique, so a lookup matches at most one way.
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) |-> $onehot0(match))
		else $error("tag matched in more than one way");

	// A committed flush leaves the set empty.
	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && look_s2.is_flush) |=> (valid_q == '0))
		else $error("flush left valid lines");

	// A miss on a full set always finds a victim.
	a_victim_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK && look.full && !look.hit && !req_s1.is_flush) |-> nd_v[1])
		else $error("full set without a victim");

endmodule

`default_nettype wire

>>> src/lfu_cache_set_lru_tiebreak_top.sv
// Top level of the LFU cache set with recency tie-break, and its way limit register.
//
// Usage: one request channel (req_valid, req_stall, req) carries an access with a
// tag or a flush; one result channel (rsp_valid, rsp_stall, rsp) returns exactly
// one result per request, in order. A transfer happens at a rising edge of clk
// where valid is high and stall is low.
// A two-entry queue sits behind the request port, so requests are taken while
// the set is busy until the queue fills; req_stall is high only when it is full.
// Each request takes a lookup step (tag compare and the victim search tree), then
// an update step (the line update); no new lookup starts before the last request
// commits. A finished result waits in an output register; while rsp_stall holds
// it, the next request still completes its lookup and then waits, and the queue
// keeps filling. The way limit (cfg_wr_en, cfg_wr_data) is to be written only
// while idle; the block does not enforce this. Zero acts as one and values above
// the way count act as the way count.
// Reset (arst_n low) empties the set and the queue, drops any pending result
// and sets the way limit to eight. No clearing pass follows reset.
`default_nettype none

module lfu_cache_set_lru_tiebreak_top (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            req_valid,
	output logic                           req_stall,
	input  lfu_pkg::req_t                  req,
	output logic                           rsp_valid,
	input  wire                            rsp_stall,
	output lfu_pkg::rsp_t                  rsp,
	input  wire                            cfg_wr_en,
	input  wire [lfu_pkg::CFG_BITS-1:0]    cfg_wr_data
);
	import lfu_pkg::*;

	logic [CFG_BITS-1:0] ways_q;
	logic [OCC_BITS-1:0] limit;
	logic                q_valid;
	logic                q_pop;
	item_t               q_item;

	// Way limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ways_q <= WAYS_IN_USE_RST;
		end else if (cfg_wr_en) begin
			ways_q <= cfg_wr_data;
		end
	end

	// Clamp the limit into one through the way count.
	always_comb begin
		if (ways_q == '0) begin
			limit = OCC_BITS'(1);
		end else if (32'(ways_q) > WAYS) begin
			limit = OCC_BITS'(WAYS);
		end else begin
			limit = OCC_BITS'(ways_q);
		end
	end

	lfu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item)
	);

	lfu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.limit     (limit),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
